// ----- design/lzss_pkg.sv -----
`default_nettype none

package lzss_pkg;

  localparam int WINDOW_BYTES = 4096;
  localparam int WIN_AW = $clog2(WINDOW_BYTES);
  localparam int DIST_W = WIN_AW + 1;
  localparam int SIZE_W = 24;
  localparam int LEN_W = 5;
  localparam int POS_W = 4;
  localparam int MIN_MATCH = 3;
  localparam int FLAG_COUNT = 8;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 24'hFF_FFFF;

  localparam logic [1:0] PHASE_FLAG  = 2'd0;
  localparam logic [1:0] PHASE_TOKEN = 2'd1;
  localparam logic [1:0] PHASE_MATCH = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_end;
    logic       stream_done;
    logic       bad_reference;
  } result_t;

endpackage

`default_nettype wire

// ----- design/lzss_window_decompressor.sv -----
`default_nettype none

// LZSS decompressor with a 4096-byte history window.
// The input channel (in_valid, in_stall, in_byte, in_last) takes one compressed
// word at a time, starting with the flag byte that follows the size header.
// The output channel (out_valid, out_stall and the result fields) gives one
// word per decompressed byte, or one status word at the end of the stream or
// on a bad match reference. The size from the header is written through
// cfg_write and cfg_data; the user must do so only while the block is idle,
// which the block itself does not enforce. A flag byte or first match byte
// passes the idle, calc and decode states, a literal also the emit state, and
// the second match byte then read and emit for each copied byte. Each copied
// byte needs one read and then one write of the history memory.
// The block holds in_stall high while it works on a word. When the receiver
// stalls, the finished word waits in the output register and decoding waits
// with it. Reset clears the decoder state and sets the size to its maximum;
// the history memory needs no clearing, so the block is ready right after
// reset. After the end of the stream or an error, input words are taken and
// dropped until the next reset.
module lzss_window_decompressor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_byte,
  output logic             byte_valid,
  output logic             run_end,
  output logic             stream_done,
  output logic             bad_reference
);

  import lzss_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CALC   = 6'b000010,
    S_DECODE = 6'b000100,
    S_STATUS = 6'b001000,
    S_READ   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   output_size;
  logic [SIZE_W-1:0]   produced;
  logic [SIZE_W-1:0]   remaining;
  logic                limit_hit;
  logic                halted;
  logic [1:0]          phase;
  logic [POS_W-1:0]    flag_pos;
  logic [7:0]          flag_bits;
  logic [7:0]          match_high;
  logic [7:0]          cur_byte;
  logic                cur_last;
  logic [LEN_W-1:0]    copy_left;
  logic [WIN_AW-1:0]   rd_addr;
  logic                is_lit;
  logic                done_final;
  logic                status_bad;

  logic [SIZE_W:0]     diff;
  logic [POS_W-1:0]    pos_inc;
  logic [WIN_AW-1:0]   field;
  logic [DIST_W-1:0]   distance;
  logic [LEN_W-1:0]    len_raw;
  logic                cut;
  logic [LEN_W-1:0]    len;
  logic                slot_free;
  logic                load;
  logic [7:0]          ram_rdata;
  logic [7:0]          emit_byte;
  result_t             res_d;
  result_t             res_q;

  assign in_stall = (state != S_IDLE);

  assign diff     = {1'b0, output_size} - {1'b0, produced};
  assign pos_inc  = flag_pos + POS_W'(1);
  assign field    = {match_high[3:0], cur_byte};
  assign distance = DIST_W'(WINDOW_BYTES) - {1'b0, field};
  assign len_raw  = LEN_W'(match_high[7:4]) + LEN_W'(MIN_MATCH);
  assign cut      = SIZE_W'(len_raw) > remaining;
  assign len      = cut ? remaining[LEN_W-1:0] : len_raw;

  assign emit_byte = is_lit ? cur_byte : ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      output_size <= SIZE_RESET;
      produced    <= '0;
      halted      <= 1'b0;
      phase       <= PHASE_FLAG;
      flag_pos    <= POS_W'(FLAG_COUNT);
      flag_bits   <= '0;
      match_high  <= '0;
    end else begin
      if (cfg_write) begin
        output_size <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !halted) begin
            cur_byte <= in_byte;
            cur_last <= in_last;
            state    <= S_CALC;
          end
        end
        S_CALC: begin
          remaining <= diff[SIZE_W-1:0];
          limit_hit <= diff[SIZE_W] || (diff[SIZE_W-1:0] == '0);
          state     <= S_DECODE;
        end
        S_DECODE: begin
          status_bad <= 1'b0;
          if (limit_hit) begin
            state <= S_STATUS;
          end else begin
            case (phase)
              PHASE_FLAG: begin
                flag_bits <= cur_byte;
                flag_pos  <= '0;
                phase     <= PHASE_TOKEN;
                state     <= cur_last ? S_STATUS : S_IDLE;
              end
              PHASE_TOKEN: begin
                if (flag_bits[flag_pos[2:0]]) begin
                  if (pos_inc >= POS_W'(FLAG_COUNT)) begin
                    flag_pos <= POS_W'(FLAG_COUNT);
                    phase    <= PHASE_FLAG;
                  end else begin
                    flag_pos <= pos_inc;
                  end
                  copy_left  <= LEN_W'(1);
                  is_lit     <= 1'b1;
                  done_final <= cur_last || (remaining == SIZE_W'(1));
                  state      <= S_EMIT;
                end else begin
                  match_high <= cur_byte;
                  phase      <= PHASE_MATCH;
                  state      <= cur_last ? S_STATUS : S_IDLE;
                end
              end
              default: begin
                if (pos_inc >= POS_W'(FLAG_COUNT)) begin
                  flag_pos <= POS_W'(FLAG_COUNT);
                  phase    <= PHASE_FLAG;
                end else begin
                  flag_pos <= pos_inc;
                  phase    <= PHASE_TOKEN;
                end
                if (len >= LEN_W'(2)) begin
                  if (SIZE_W'(distance) > produced) begin
                    status_bad <= 1'b1;
                    state      <= S_STATUS;
                  end else begin
                    copy_left  <= len;
                    is_lit     <= 1'b0;
                    rd_addr    <= produced[WIN_AW-1:0] + field;
                    done_final <= cur_last || cut || (SIZE_W'(len) == remaining);
                    state      <= S_READ;
                  end
                end else begin
                  state <= S_STATUS;
                end
              end
            endcase
          end
        end
        S_STATUS: begin
          if (slot_free) begin
            halted <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            produced  <= produced + SIZE_W'(1);
            rd_addr   <= rd_addr + WIN_AW'(1);
            copy_left <= copy_left - LEN_W'(1);
            if (copy_left == LEN_W'(1)) begin
              if (done_final) begin
                halted <= 1'b1;
              end
              state <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res_d = '0;
    load  = 1'b0;
    if (state == S_STATUS) begin
      load              = slot_free;
      res_d.run_end     = 1'b1;
      res_d.stream_done = !status_bad;
      res_d.bad_reference = status_bad;
    end else if (state == S_EMIT) begin
      load              = slot_free;
      res_d.out_byte    = emit_byte;
      res_d.byte_valid  = 1'b1;
      res_d.run_end     = (copy_left == LEN_W'(1));
      res_d.stream_done = (copy_left == LEN_W'(1)) && done_final;
    end
  end

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_history (
    .clk   (clk),
    .we    ((state == S_EMIT) && slot_free),
    .waddr (produced[WIN_AW-1:0]),
    .wdata (emit_byte),
    .re    (state == S_READ),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  lzss_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .d         (res_d),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .q         (res_q),
    .slot_free (slot_free)
  );

  assign out_byte      = res_q.out_byte;
  assign byte_valid    = res_q.byte_valid;
  assign run_end       = res_q.run_end;
  assign stream_done   = res_q.stream_done;
  assign bad_reference = res_q.bad_reference;

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("Halted flag cleared without reset.");

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> run_end)
    else $error("Status word without run end.");

  a_bad_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_reference) |-> (!byte_valid && !stream_done))
    else $error("Bad reference word carries data or stream end.");

  a_copy_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (copy_left != '0))
    else $error("Copy emits with an empty count.");

endmodule

`default_nettype wire

// ----- design/lzss_ram.sv -----
`default_nettype none

module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/lzss_out_reg.sv -----
`default_nettype none

module lzss_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire lzss_pkg::result_t d,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output lzss_pkg::result_t      q,
  output logic                   slot_free
);

  import lzss_pkg::*;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
  import lzss_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_RUN = 15 + MIN_MATCH;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_WORDS = 400;
  localparam int TIMEOUT_CYCLES = 700000;
  localparam int MAX_PRINTED = 40;

  typedef enum int {
    END_LAST_TOKEN,
    END_LAST_FLAG,
    END_LAST_MATCH_HIGH,
    END_SIZE_LIMIT,
    END_SIZE_BELOW,
    END_BAD_REF
  } end_case_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = '0;
  logic        in_last = 1'b0;
  logic        out_stall = 1'b0;
  wire logic       in_stall;
  wire logic       out_valid;
  wire logic [7:0] out_byte;
  wire logic       byte_valid;
  wire logic       run_end;
  wire logic       stream_done;
  wire logic       bad_reference;

  lzss_window_decompressor i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .byte_valid(byte_valid),
    .run_end(run_end),
    .stream_done(stream_done),
    .bad_reference(bad_reference)
  );

  logic [7:0]        win_mem [WINDOW_BYTES];
  logic [7:0]        token_flags = '0;
  logic [POS_W-1:0]  token_index = POS_W'(FLAG_COUNT);
  logic [1:0]        decode_phase = PHASE_FLAG;
  logic [7:0]        pair_high = '0;
  logic [SIZE_W-1:0] written_count = '0;
  logic              stopped = 1'b0;
  logic [SIZE_W-1:0] size_limit = SIZE_RESET;

  result_t   expected_output [$];
  int        error_count = 0;
  int        words_checked = 0;
  int        words_sent = 0;
  int        burst_left = 0;
  logic      hold_request = 1'b0;
  end_case_t end_case = END_LAST_TOKEN;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Verification failed");
    $finish;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic result_t store_byte(input logic [7:0] b);
    result_t r;
    win_mem[written_count[WIN_AW-1:0]] = b;
    written_count = written_count + 1'b1;
    r = '0;
    r.out_byte = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic result_t status_word(input logic bad);
    result_t r;
    r = '0;
    r.run_end = 1'b1;
    r.bad_reference = bad;
    return r;
  endfunction

  task automatic decode_word(input logic [7:0] b, input logic last);
    result_t           run [0:MAX_RUN-1];
    int                n;
    logic              done;
    logic              bad;
    logic              cut;
    logic              token_done;
    int unsigned       len;
    int unsigned       distance;
    int unsigned       remaining;
    logic [15:0]       pair;
    logic [WIN_AW-1:0] rd;
    n = 0;
    done = 1'b0;
    bad = 1'b0;
    cut = 1'b0;
    token_done = 1'b0;
    if (!stopped) begin
      if (written_count >= size_limit) begin
        done = 1'b1;
      end else if (decode_phase == PHASE_FLAG) begin
        token_flags = b;
        token_index = '0;
        decode_phase = PHASE_TOKEN;
      end else if (decode_phase == PHASE_TOKEN) begin
        if (token_flags[token_index[2:0]]) begin
          run[n] = store_byte(b);
          n++;
          token_done = 1'b1;
        end else begin
          pair_high = b;
          decode_phase = PHASE_MATCH;
        end
      end else begin
        pair = {pair_high, b};
        len = 32'(pair[15:12]) + MIN_MATCH;
        distance = WINDOW_BYTES - 32'(pair[11:0]);
        remaining = 32'(size_limit - written_count);
        if (len > remaining) begin
          len = remaining;
          cut = 1'b1;
        end
        if (len >= 2) begin
          if (distance > 32'(written_count)) begin
            bad = 1'b1;
          end else begin
            rd = written_count[WIN_AW-1:0] - distance[WIN_AW-1:0];
            for (int i = 0; i < int'(len); i++) begin
              run[n] = store_byte(win_mem[rd]);
              n++;
              rd++;
            end
          end
        end
        token_done = 1'b1;
      end

      if (token_done) begin
        token_index++;
        if (token_index >= POS_W'(FLAG_COUNT)) begin
          token_index = POS_W'(FLAG_COUNT);
          decode_phase = PHASE_FLAG;
        end else begin
          decode_phase = PHASE_TOKEN;
        end
      end

      if (bad) begin
        expected_output.push_back(status_word(1'b1));
        stopped = 1'b1;
      end else begin
        if (last || cut || written_count >= size_limit) done = 1'b1;
        if (done) begin
          if (n == 0) begin
            run[0] = status_word(1'b0);
            n = 1;
          end
          run[n-1].stream_done = 1'b1;
          stopped = 1'b1;
        end
        if (n > 0) run[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++) expected_output.push_back(run[i]);
      end
    end
  endtask

  task automatic check_word();
    result_t want;
    words_checked++;
    if (expected_output.size() == 0) begin
      report_error($sformatf("word %0d arrived with none expected, byte %h",
                             words_checked, out_byte));
    end else begin
      want = expected_output.pop_front();
      if (out_byte !== want.out_byte)
        report_error($sformatf("word %0d out_byte %h, expected %h",
                               words_checked, out_byte, want.out_byte));
      if (byte_valid !== want.byte_valid)
        report_error($sformatf("word %0d byte_valid %b, expected %b",
                               words_checked, byte_valid, want.byte_valid));
      if (run_end !== want.run_end)
        report_error($sformatf("word %0d run_end %b, expected %b",
                               words_checked, run_end, want.run_end));
      if (stream_done !== want.stream_done)
        report_error($sformatf("word %0d stream_done %b, expected %b",
                               words_checked, stream_done, want.stream_done));
      if (bad_reference !== want.bad_reference)
        report_error($sformatf("word %0d bad_reference %b, expected %b",
                               words_checked, bad_reference, want.bad_reference));
    end
  endtask

  // The receiver alternates free stretches and short stalls, and holds off for
  // a long stretch whenever a test asks for it.
  initial begin
    int free_left;
    int stall_left;
    int hold_left;
    free_left = 0;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_word();
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        free_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 12);
        stall_left = $urandom_range(1, 5);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_word(b, last);
    words_sent++;
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_output.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    size_limit = value;
  endtask

  function automatic int unsigned pick_distance();
    int unsigned reach;
    int unsigned distance;
    reach = 32'(written_count);
    if (reach > WINDOW_BYTES) reach = WINDOW_BYTES;
    case ($urandom_range(0, 3))
      0: distance = $urandom_range(1, (reach < 4) ? reach : 4);
      1: distance = reach;
      default: distance = $urandom_range(1, reach);
    endcase
    return distance;
  endfunction

  task automatic send_match(input logic [3:0] nib, input int unsigned distance,
                            input logic last);
    logic [11:0] field;
    field = 12'(WINDOW_BYTES - distance);
    send_word({nib, field[11:8]}, 1'b0);
    send_word(field[7:0], last);
  endtask

  task automatic send_token(input logic literal, input logic last);
    logic [3:0] nib;
    if (literal) begin
      send_word(8'($urandom), last);
    end else if (written_count >= WINDOW_BYTES && $urandom_range(0, 4) == 0) begin
      // With a full window every distance is legal, so the pair can be anything.
      send_word(8'($urandom), 1'b0);
      send_word(8'($urandom), last);
    end else begin
      nib = $urandom_range(0, 1) ? 4'hF : 4'($urandom);
      send_match(nib, pick_distance(), last);
    end
  endtask

  task automatic send_group();
    logic [7:0] flags;
    flags = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom & $urandom);
    send_word(flags, 1'b0);
    for (int i = 0; i < FLAG_COUNT; i++) send_token(flags[i], 1'b0);
  endtask

  task automatic test_directed();
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'hFE, 1'b0);
    send_word(8'hF0, 1'b0);
    send_match(4'h0, 1, 1'b0);
    send_match(4'hF, 1, 1'b0);
    send_match(4'h0, 32'(written_count), 1'b0);
    send_match(4'hF, 32'(written_count), 1'b0);
    send_word(8'h3C, 1'b0);
    send_word(8'hC3, 1'b0);
    send_word(8'h0F, 1'b0);
    send_word(8'hF0, 1'b0);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    burst_left = 60;
    repeat (3) send_group();
    burst_left = 0;
  endtask

  task automatic test_random_stream();
    while (words_sent < RANDOM_WORDS) send_group();
  endtask

  task automatic test_stream_end();
    logic [7:0] flags;
    int         stop;
    if (end_case == END_BAD_REF && written_count >= WINDOW_BYTES) end_case = END_SIZE_BELOW;
    case (end_case)
      END_LAST_TOKEN: begin
        flags = 8'($urandom);
        stop = $urandom_range(0, FLAG_COUNT - 1);
        send_word(flags, 1'b0);
        for (int i = 0; i < stop; i++) send_token(flags[i], 1'b0);
        send_token(flags[stop], 1'b1);
      end
      END_LAST_FLAG: begin
        send_word(8'($urandom), 1'b1);
      end
      END_LAST_MATCH_HIGH: begin
        send_word(8'($urandom) & 8'hFE, 1'b0);
        send_word(8'($urandom), 1'b1);
      end
      END_SIZE_LIMIT: begin
        write_size(written_count + 24'($urandom_range(1, 30)));
        while (!stopped) send_group();
      end
      END_SIZE_BELOW: begin
        write_size(24'd1);
        send_word(8'($urandom), 1'b0);
      end
      default: begin
        send_word(8'($urandom) & 8'hFE, 1'b0);
        send_match(4'($urandom), $urandom_range(32'(written_count) + 1, WINDOW_BYTES), 1'b0);
      end
    endcase
    // The block has stopped; these words must be taken and dropped.
    repeat (4) send_word(8'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    end_case = end_case_t'($urandom_range(0, 5));
    write_size(SIZE_RESET);
    test_directed();
    write_size(24'($urandom_range(20000, 24'hFF_FFFE)));
    test_backpressure();
    test_random_stream();
    test_stream_end();
    in_valid <= 1'b0;
    while (expected_output.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- lzss_window_decompressor.f -----
design/lzss_pkg.sv
design/lzss_ram.sv
design/lzss_out_reg.sv
design/lzss_window_decompressor.sv
verif/tb.sv
